FILE: rtl/btcs_pkg.sv
// ----------------------------------------------------------------------------
// btcs_pkg - shared types and codes for the block transfer command splitter
// Beat layouts, phase encoding, function codes, opcodes, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package btcs_pkg;

    // request function codes
    localparam logic [1:0] FUNC_READ     = 2'd0;
    localparam logic [1:0] FUNC_WRITE    = 2'd1;
    localparam logic [1:0] FUNC_COMPLETE = 2'd2;

    // SCSI operation bytes
    localparam logic [7:0] OP_READ10  = 8'h28;
    localparam logic [7:0] OP_WRITE10 = 8'h2A;
    localparam logic [7:0] OP_READ16  = 8'h88;

    localparam logic [4:0] CDB_LEN_SHORT = 5'd10;
    localparam logic [4:0] CDB_LEN_LONG  = 5'd16;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_MAX_BLOCKS  = 3'd0;
    localparam logic [2:0] REG_BLOCK_SIZE  = 3'd1;
    localparam logic [2:0] REG_UNIT_NUMBER = 3'd2;
    localparam logic [2:0] REG_OMIT_UNIT   = 3'd3;
    localparam logic [2:0] REG_WIDE_LBA    = 3'd4;

    localparam logic [15:0] MAX_BLOCKS_RST = 16'hFFFF;
    localparam logic [16:0] BLOCK_SIZE_RST = 17'd512;
    localparam logic [16:0] BLOCK_SIZE_TOP = 17'd65536;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_READ  = 2'd1,
        PH_WRITE = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] start_block;
        logic [31:0] block_count;
        logic        command_failed;
    } t_in_beat;

    typedef struct packed {
        logic        is_finish;
        logic [7:0]  opcode;
        logic [7:0]  unit_byte;
        logic [63:0] block_address;
        logic [15:0] command_blocks;
        logic [4:0]  command_length;
        logic [31:0] byte_length;
        logic        to_device;
        logic [31:0] blocks_done;
        logic        io_error;
    } t_out_beat;

endpackage

`default_nettype wire

FILE: rtl/block_transfer_command_splitter.sv
// ----------------------------------------------------------------------------
// block_transfer_command_splitter - splits block requests into SCSI commands
// Data path: an accepted input beat is captured in the input register and its
// result is then written to the result register, or to the skid stage while
// the result register is held. Throughput: one beat per cycle while the output
// is not stalled. While a result is held downstream the input takes at most
// one further beat, which moves into a one-deep skid stage.
// Reset: synchronous active low; clears phase, split state, valids and the
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module block_transfer_command_splitter (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // request / completion beats
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire btcs_pkg::t_in_beat i_in_data,
    // command / finish beats
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output btcs_pkg::t_out_beat   o_out_data,
    // configuration
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire [4:0]             paddr,
    input  wire [31:0]            pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Configuration registers (stored already saturated)
    // ------------------------------------------------------------------
    logic [15:0] r_max_blocks;
    logic [16:0] r_block_size;
    logic [2:0]  r_unit_number;
    logic        r_omit_unit;
    logic        r_wide_lba;

    logic        w_cfg_wr;
    logic [2:0]  w_cfg_idx;
    logic [16:0] w_bs_sat;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_cfg_idx = paddr[4:2];

    always_comb begin
        if (pwdata[16:0] == 17'd0) begin
            w_bs_sat = 17'd1;
        end else if (pwdata[16:0] > btcs_pkg::BLOCK_SIZE_TOP) begin
            w_bs_sat = btcs_pkg::BLOCK_SIZE_TOP;
        end else begin
            w_bs_sat = pwdata[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_blocks  <= btcs_pkg::MAX_BLOCKS_RST;
            r_block_size  <= btcs_pkg::BLOCK_SIZE_RST;
            r_unit_number <= 3'd0;
            r_omit_unit   <= 1'b0;
            r_wide_lba    <= 1'b1;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                btcs_pkg::REG_MAX_BLOCKS: begin
                    r_max_blocks <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
                end
                btcs_pkg::REG_BLOCK_SIZE:  r_block_size  <= w_bs_sat;
                btcs_pkg::REG_UNIT_NUMBER: r_unit_number <= pwdata[2:0];
                btcs_pkg::REG_OMIT_UNIT:   r_omit_unit   <= pwdata[0];
                btcs_pkg::REG_WIDE_LBA:    r_wide_lba    <= pwdata[0];
                default: ;  // unmapped addresses ignored
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            btcs_pkg::REG_MAX_BLOCKS:  prdata = {16'd0, r_max_blocks};
            btcs_pkg::REG_BLOCK_SIZE:  prdata = {15'd0, r_block_size};
            btcs_pkg::REG_UNIT_NUMBER: prdata = {29'd0, r_unit_number};
            btcs_pkg::REG_OMIT_UNIT:   prdata = {31'd0, r_omit_unit};
            btcs_pkg::REG_WIDE_LBA:    prdata = {31'd0, r_wide_lba};
            default:                   prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Beat buffering: input register -> result register (+ skid)
    // The input stage never holds a beat back, so the only back
    // pressure comes from the result side. Stall when the skid is full,
    // or when the beat in flight will itself land in the skid.
    // ------------------------------------------------------------------
    logic                r_in_valid;
    btcs_pkg::t_in_beat  r_in;
    logic                r_out_valid, n_out_valid;
    btcs_pkg::t_out_beat r_out, n_out;
    logic                r_skid_valid, n_skid_valid;
    btcs_pkg::t_out_beat r_skid;
    logic                w_in_accept;
    logic                w_out_take;

    assign o_in_stall  = r_skid_valid | (r_in_valid & r_out_valid & i_out_stall);
    assign w_in_accept = i_in_valid & ~o_in_stall;
    assign w_out_take  = r_out_valid & ~i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Split state
    // ------------------------------------------------------------------
    btcs_pkg::t_phase r_phase, n_phase;
    logic [63:0]      r_next_block, n_next_block;
    logic [31:0]      r_blocks_left, n_blocks_left;
    logic [31:0]      r_blocks_asked, n_blocks_asked;
    logic [15:0]      r_chunk_blocks, n_chunk_blocks;

    // decoded beat
    logic             w_start, w_comp;
    logic             w_emit, w_emit_cmd;
    btcs_pkg::t_phase w_ph;      // phase the command runs under
    logic [63:0]      w_nb;      // start block of the command
    logic [31:0]      w_nl;      // blocks still to go
    logic [31:0]      w_asked;
    logic [15:0]      w_n;       // blocks in this command
    logic             w_wide;
    logic [32:0]      w_prod;
    btcs_pkg::t_out_beat w_res;

    always_comb begin
        w_start = r_in_valid & ((r_in.func == btcs_pkg::FUNC_READ) |
                                (r_in.func == btcs_pkg::FUNC_WRITE));
        w_comp  = r_in_valid & (r_in.func == btcs_pkg::FUNC_COMPLETE) &
                  (r_phase != btcs_pkg::PH_IDLE);

        if (w_start) begin
            w_ph    = (r_in.func == btcs_pkg::FUNC_READ) ? btcs_pkg::PH_READ
                                                         : btcs_pkg::PH_WRITE;
            w_nb    = r_in.start_block;
            w_nl    = r_in.block_count;
            w_asked = r_in.block_count;
        end else begin
            w_ph    = r_phase;
            w_nb    = r_next_block + {48'd0, r_chunk_blocks};
            w_nl    = r_blocks_left - {16'd0, r_chunk_blocks};
            w_asked = r_blocks_asked;
        end

        // a start always issues a command (zero-count one too);
        // a good completion issues one while blocks remain
        w_emit_cmd = w_start | (w_comp & ~r_in.command_failed & (w_nl != 32'd0));
        w_emit     = w_start | w_comp;

        w_n    = (w_nl > {16'd0, r_max_blocks}) ? r_max_blocks : w_nl[15:0];
        w_wide = (w_ph == btcs_pkg::PH_READ) & r_wide_lba & (|w_nb[63:28]);
        w_prod = r_block_size * w_n;
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_start) begin
            n_phase = w_ph;
        end else if (w_comp & ~w_emit_cmd) begin
            n_phase = btcs_pkg::PH_IDLE;
        end
    end

    // result and split state update
    always_comb begin
        n_next_block   = r_next_block;
        n_blocks_left  = r_blocks_left;
        n_blocks_asked = r_blocks_asked;
        n_chunk_blocks = r_chunk_blocks;
        w_res          = '0;

        if (w_start | (w_comp & ~r_in.command_failed)) begin
            n_next_block  = w_nb;
            n_blocks_left = w_nl;
        end
        if (w_start) begin
            n_blocks_asked = w_asked;
        end

        if (w_emit_cmd) begin
            n_chunk_blocks       = w_n;
            w_res.is_finish      = 1'b0;
            if (w_ph == btcs_pkg::PH_WRITE) begin
                w_res.opcode = btcs_pkg::OP_WRITE10;
            end else begin
                w_res.opcode = w_wide ? btcs_pkg::OP_READ16 : btcs_pkg::OP_READ10;
            end
            w_res.unit_byte      = r_omit_unit ? 8'd0 : {r_unit_number, 5'd0};
            w_res.block_address  = w_wide ? w_nb : {32'd0, w_nb[31:0]};
            w_res.command_blocks = w_n;
            w_res.command_length = w_wide ? btcs_pkg::CDB_LEN_LONG
                                          : btcs_pkg::CDB_LEN_SHORT;
            w_res.byte_length    = w_prod[31:0];
            w_res.to_device      = (w_ph == btcs_pkg::PH_WRITE);
        end else begin
            // finish: on failure count from the state before the completion
            w_res.is_finish = 1'b1;
            if (r_in.command_failed) begin
                w_res.blocks_done = r_blocks_asked - r_blocks_left;
                w_res.io_error    = (r_blocks_left == r_blocks_asked);
            end else begin
                w_res.blocks_done = r_blocks_asked;
                w_res.io_error    = (r_blocks_asked == 32'd0);
            end
        end
    end

    // result register / skid steering
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || w_out_take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_emit;
                n_out       = w_res;
            end
        end else if (w_emit) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
            r_phase        <= btcs_pkg::PH_IDLE;
            r_next_block   <= 64'd0;
            r_blocks_left  <= 32'd0;
            r_blocks_asked <= 32'd0;
            r_chunk_blocks <= 16'd0;
        end else begin
            r_in_valid     <= w_in_accept;
            r_out_valid    <= n_out_valid;
            r_skid_valid   <= n_skid_valid;
            r_phase        <= n_phase;
            r_next_block   <= n_next_block;
            r_blocks_left  <= n_blocks_left;
            r_blocks_asked <= n_blocks_asked;
            r_chunk_blocks <= n_chunk_blocks;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in <= i_in_data;
        end
        r_out <= n_out;
        if (r_out_valid && !w_out_take && w_emit) begin
            r_skid <= w_res;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while the result register is empty");

    a_skid_no_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !r_in_valid)
        else $error("beat in the input stage with the skid already full");

    a_finish_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_comp && !w_emit_cmd) |=> (r_phase == btcs_pkg::PH_IDLE))
        else $error("phase not idle after a finish report");

    a_max_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max_blocks != 16'd0)
        else $error("max_blocks register holds zero");

endmodule

`default_nettype wire
